### hw/rtl/cobs_rx_pkg.sv
// Shared types, status codes and the byte-wide CRC-16/CCITT update for the
// COBS frame receiver. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cobs_rx_pkg;

  localparam int unsigned MAX_RAW_DEF = 512;
  localparam logic [15:0] CRC_SEED_RST = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  CODE_FULL = 8'hFF;
  localparam logic [8:0]  LEN_MAX = 9'h1FF;

  typedef enum logic [2:0] {
    ST_GOOD   = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_TRUNC  = 3'd2,
    ST_SHORT  = 3'd3,
    ST_CRCBAD = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_frame;
    status_e    frame_status;
    logic [8:0] payload_length;
  } result_t;

  // MSB first, no reflection, no final xor
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/cobs_rx_in_stage.sv
// Input register for raw link bytes.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module cobs_rx_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       take_i,
  output logic            item_valid_o,
  output logic [7:0]      item_byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_byte_o  = byte_q;

endmodule

`default_nettype wire

### hw/rtl/cobs_rx_decode.sv
// Per-byte COBS decode, two-byte CRC hold line, running CRC and frame status.
// Depends on cobs_rx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cobs_rx_decode
  import cobs_rx_pkg::*;
#(
  parameter int unsigned MAX_RAW = MAX_RAW_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic [15:0] seed_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  localparam int unsigned CW = $clog2(MAX_RAW + 1);
  localparam int unsigned RW = (CW > 10) ? CW : 10;

  logic [CW-1:0] raw_q, raw_d;
  logic [CW-1:0] dc_q, dc_d;
  logic [7:0]    left_q, left_d;
  logic [7:0]    code_q, code_d;
  logic          zp_q, zp_d;
  logic [7:0]    hold0_q, hold0_d, hold1_q, hold1_d;
  logic [1:0]    fill_q, fill_d;
  logic [15:0]   crc_q, crc_d;

  logic [15:0]   crc_base;
  logic [RW-1:0] released;
  logic          push;
  logic [7:0]    push_byte;
  status_e       status;

  assign crc_base = (dc_q <= CW'(2)) ? seed_i : crc_q;
  assign released = RW'(dc_q) - RW'(fill_q);

  always_comb begin
    if (left_q != 8'd0) begin
      status = ST_TRUNC;
    end else if (dc_q == '0) begin
      status = ST_EMPTY;
    end else if (dc_q == CW'(1)) begin
      status = ST_SHORT;
    end else if ({hold0_q, hold1_q} == crc_base) begin
      status = ST_GOOD;
    end else begin
      status = ST_CRCBAD;
    end
  end

  always_comb begin
    raw_d     = raw_q;
    dc_d      = dc_q;
    left_d    = left_q;
    code_d    = code_q;
    zp_d      = zp_q;
    hold0_d   = hold0_q;
    hold1_d   = hold1_q;
    fill_d    = fill_q;
    crc_d     = crc_q;
    push      = 1'b0;
    push_byte = byte_i;
    res_valid_o = 1'b0;
    res_o       = '{out_byte: 8'h00, end_of_frame: 1'b0, frame_status: ST_GOOD,
                    payload_length: 9'd0};

    if (fire_i) begin
      if (byte_i == 8'h00) begin
        res_valid_o          = 1'b1;
        res_o.end_of_frame   = 1'b1;
        res_o.frame_status   = status;
        res_o.payload_length = (released > RW'(LEN_MAX)) ? LEN_MAX : released[8:0];
        raw_d   = '0;
        dc_d    = '0;
        left_d  = 8'd0;
        code_d  = 8'd0;
        zp_d    = 1'b0;
        hold0_d = 8'h00;
        hold1_d = 8'h00;
        fill_d  = 2'd0;
        crc_d   = seed_i;
      end else if (raw_q < CW'(MAX_RAW)) begin
        raw_d = raw_q + CW'(1);
        if (left_q == 8'd0) begin
          push      = zp_q;
          push_byte = 8'h00;
          code_d    = byte_i;
          left_d    = byte_i - 8'd1;
          zp_d      = (byte_i == 8'd1);
        end else begin
          push   = 1'b1;
          left_d = left_q - 8'd1;
          if (left_q == 8'd1 && code_q != CODE_FULL) begin
            zp_d = 1'b1;
          end
        end

        if (push) begin
          dc_d = dc_q + CW'(1);
          if (fill_q[1]) begin
            res_valid_o    = 1'b1;
            res_o.out_byte = hold0_q;
            crc_d          = crc_update(crc_base, hold0_q);
            hold0_d        = hold1_q;
            hold1_d        = push_byte;
          end else begin
            if (fill_q[0]) begin
              hold1_d = push_byte;
            end else begin
              hold0_d = push_byte;
            end
            fill_d = fill_q + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q   <= '0;
      dc_q    <= '0;
      left_q  <= 8'd0;
      code_q  <= 8'd0;
      zp_q    <= 1'b0;
      hold0_q <= 8'h00;
      hold1_q <= 8'h00;
      fill_q  <= 2'd0;
      crc_q   <= CRC_SEED_RST;
    end else begin
      raw_q   <= raw_d;
      dc_q    <= dc_d;
      left_q  <= left_d;
      code_q  <= code_d;
      zp_q    <= zp_d;
      hold0_q <= hold0_d;
      hold1_q <= hold1_d;
      fill_q  <= fill_d;
      crc_q   <= crc_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cobs_rx_out_stage.sv
// Result register toward the downstream stream port.
// Depends on cobs_rx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cobs_rx_out_stage
  import cobs_rx_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_valid_i,
  input  result_t   res_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output result_t   out_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

`default_nettype wire

### hw/rtl/cobs_crc16_frame_receiver.sv
// COBS frame receiver with CRC-16/CCITT check, top level.
// Depends on cobs_rx_pkg, cobs_rx_in_stage, cobs_rx_decode, cobs_rx_out_stage.
//
// Takes one raw link byte per cycle and sustains that rate while m_axis_tready
// stays high; a stalled output holds s_axis_tready low in the same cycle once the
// input register holds a byte. Each byte goes through an input register,
// combinational decode and CRC logic, and a result register. A zero byte
// closes the frame with a status item (tlast high). The two trailing
// decoded bytes are the big-endian CRC and are never sent as payload. Bytes
// of a bad frame are already sent when the status arrives; discard the frame
// on any nonzero status. Write crc_seed only while the link is idle.
`timescale 1ns / 1ps
`default_nettype none

module cobs_crc16_frame_receiver
  import cobs_rx_pkg::*;
#(
  parameter int unsigned MAX_RAW = MAX_RAW_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] out_byte, [16:8] payload_length
  output logic             m_axis_tlast,   // end_of_frame
  output logic [2:0]       m_axis_tuser,   // [2:0] frame_status
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i     // crc_seed
);

  logic [15:0] seed_q;
  logic        item_valid;
  logic [7:0]  item_byte;
  logic        out_ready;
  logic        fire;
  logic        res_valid;
  result_t     res;
  result_t     out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= CRC_SEED_RST;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  assign fire = item_valid && out_ready;

  cobs_rx_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .take_i       (fire),
    .item_valid_o (item_valid),
    .item_byte_o  (item_byte)
  );

  cobs_rx_decode #(
    .MAX_RAW (MAX_RAW)
  ) u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (item_byte),
    .seed_i      (seed_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cobs_rx_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out)
  );

  assign m_axis_tdata = {7'd0, out.payload_length, out.out_byte};
  assign m_axis_tlast = out.end_of_frame;
  assign m_axis_tuser = out.frame_status;

endmodule

`default_nettype wire

### hw/rtl/cobs_rx_checker.sv
// Port-level checks for the COBS frame receiver, bound to the top level.
// Depends on cobs_rx_pkg and cobs_crc16_frame_receiver.
`timescale 1ns / 1ps
`default_nettype none

module cobs_rx_checker
  import cobs_rx_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic [2:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result transfer dropped while stalled");

  a_end_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[7:0] == 8'h00)
    else $error("status item carries a data byte");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |->
      m_axis_tuser == ST_GOOD && m_axis_tdata[23:8] == 16'd0)
    else $error("payload item carries status or length");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tuser == ST_GOOD || m_axis_tuser == ST_EMPTY || m_axis_tuser == ST_TRUNC ||
      m_axis_tuser == ST_SHORT || m_axis_tuser == ST_CRCBAD)
    else $error("undefined frame status");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && m_axis_tuser == ST_EMPTY |->
      m_axis_tdata[16:8] == 9'd0)
    else $error("empty frame reports payload");

endmodule

bind cobs_crc16_frame_receiver cobs_rx_checker u_cobs_rx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
